FILE: design/bht_pkg.sv
// Shared types and codes for the bucketed hash table.
package bht_pkg;

	localparam int BUCKETS = 128;
	localparam int WAYS    = 4;

	localparam logic [1:0] FUNC_ADD    = 2'd0;
	localparam logic [1:0] FUNC_DEL    = 2'd1;
	localparam logic [1:0] FUNC_RD     = 2'd2;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	localparam logic [7:0] BUCKET_COUNT_RESET = 8'd100;

	// One stored record: id, six name words, gpa.
	localparam int REC_W = 31 + 64 + 64 + 32 + 64 + 64 + 32 + 10;

	typedef struct packed {
		logic [1:0]  func;
		logic [30:0] key_id;
		logic [63:0] first_name_0;
		logic [63:0] first_name_1;
		logic [31:0] first_name_2;
		logic [63:0] last_name_0;
		logic [63:0] last_name_1;
		logic [31:0] last_name_2;
		logic [9:0]  gpa_hundredths;
		logic [8:0]  slot_index;
	} bht_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [6:0]  bucket_index;
		logic [2:0]  bucket_fill_count;
		logic [30:0] out_key_id;
		logic [63:0] out_first_name_0;
		logic [63:0] out_first_name_1;
		logic [31:0] out_first_name_2;
		logic [63:0] out_last_name_0;
		logic [63:0] out_last_name_1;
		logic [31:0] out_last_name_2;
		logic [9:0]  out_gpa;
	} bht_out_t;

	typedef struct packed {
		logic [30:0] key_id;
		logic [63:0] first_name_0;
		logic [63:0] first_name_1;
		logic [31:0] first_name_2;
		logic [63:0] last_name_0;
		logic [63:0] last_name_1;
		logic [31:0] last_name_2;
		logic [9:0]  gpa;
	} bht_rec_t;

endpackage

FILE: design/bucketed_hash_table_by_id.sv
// Top level: bucketed record table keyed by id, fill counts and records in memories.
//
// Input channel in_valid/in_ready carries one transaction (bht_in_t): add,
// delete by id, or read of one slot. Output channel out_valid/out_ready
// returns exactly one result (bht_out_t) per transaction.
// Configuration: cfg_we/cfg_wdata writes bucket_count (reset 100). The user must
// write it only while idle; the block itself does not enforce this. One
// transaction is worked at a time. An add or delete first runs a bit-serial
// remainder over the 31-bit id and reads the bucket's fill count; an add then
// writes the record at the fill position, a delete walks the bucket in the
// record memory and moves later records down over the match. A read fetches
// one slot; a read beyond the table or an unused func goes straight to the result.
// A new transaction is taken the cycle after the result is taken.
// Reset sets bucket_count to 100 and starts a pass that zeroes the fill
// counts of all 128 buckets; in_ready stays low until it ends. Record
// storage is not cleared. A stalled receiver holds the result register;
// in_ready stays low until the result is taken.
module bucketed_hash_table_by_id
	import bht_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  bht_in_t    in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output bht_out_t   out_data,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int WW  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int FW  = $clog2(WAYS + 1);
	localparam int NS  = BUCKETS * WAYS;
	localparam int SW  = $clog2(NS);
	localparam int DW  = $clog2(BUCKETS + 1) > 8 ? $clog2(BUCKETS + 1) : 8;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MOD  = 4'd1;
	localparam logic [3:0] S_FILL = 4'd2;
	localparam logic [3:0] S_SRCH = 4'd3;
	localparam logic [3:0] S_SCMP = 4'd4;
	localparam logic [3:0] S_MRD  = 4'd5;
	localparam logic [3:0] S_MWR  = 4'd6;
	localparam logic [3:0] S_RD   = 4'd7;
	localparam logic [3:0] S_RDW  = 4'd8;
	localparam logic [3:0] S_OUT  = 4'd9;
	localparam logic [3:0] S_CLR  = 4'd10;

	logic [3:0]    state_q;
	logic [7:0]    bcount_q;
	logic [BW-1:0] clr_q;
	bht_in_t       item_q;
	logic [BW-1:0] bucket_q;
	logic [FW-1:0] cur_fill_q;
	logic [WW:0]   pos_q;
	bht_out_t      res_q;

	logic [FW-1:0] fill_mem [BUCKETS];
	logic [FW-1:0] fill_rdata;
	logic [BW-1:0] fill_raddr;
	logic          fill_we;
	logic [BW-1:0] fill_waddr;
	logic [FW-1:0] fill_wdata;

	bht_rec_t      mem [NS];
	bht_rec_t      rdata;
	logic [SW-1:0] raddr;
	logic          wen;
	logic [SW-1:0] waddr;
	bht_rec_t      wdata;

	logic [DW-1:0] divisor;
	logic          mod_start;
	logic          mod_done;
	logic [DW-1:0] mod_rem;
	logic [SW:0]   slot_ext;

	always_comb begin
		divisor = DW'(bcount_q);
		if (bcount_q == 8'd0) divisor = DW'(1);
		if (DW'(bcount_q) > DW'(BUCKETS)) divisor = DW'(BUCKETS);
	end

	bht_mod #(.DW(DW)) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (in_data.key_id),
		.divisor   (divisor),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	always_ff @(posedge clk) begin
		if (wen) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
		fill_rdata <= fill_mem[fill_raddr];
	end

	// the remainder is final in the last remainder cycle, so look up the fill then
	always_comb begin
		fill_raddr = (state_q == S_MOD) ? BW'(mod_rem) : bucket_q;
		fill_we    = 1'b0;
		fill_waddr = bucket_q;
		fill_wdata = '0;
		if (state_q == S_CLR) begin
			fill_we    = 1'b1;
			fill_waddr = clr_q;
		end
		if (state_q == S_FILL && item_q.func == FUNC_ADD && fill_rdata < FW'(WAYS)) begin
			fill_we    = 1'b1;
			fill_wdata = fill_rdata + 1'b1;
		end
		if (state_q == S_SCMP && rdata.key_id == item_q.key_id) begin
			fill_we    = 1'b1;
			fill_wdata = cur_fill_q - 1'b1;
		end
	end

	assign slot_ext = {1'b0, item_q.slot_index[SW-1:0]};

	always_comb begin
		raddr = {bucket_q, pos_q[WW-1:0]};
		if (WAYS == 1) raddr = SW'(bucket_q);
		else raddr = SW'({bucket_q, pos_q[WW-1:0]});
		if (state_q == S_RD) raddr = SW'(item_q.slot_index);
		wen   = 1'b0;
		waddr = raddr;
		wdata = rdata;
		if (state_q == S_FILL && item_q.func == FUNC_ADD && fill_rdata < FW'(WAYS)) begin
			wen   = 1'b1;
			waddr = SW'(bucket_q) * SW'(WAYS) + SW'(fill_rdata);
			wdata.key_id       = item_q.key_id;
			wdata.first_name_0 = item_q.first_name_0;
			wdata.first_name_1 = item_q.first_name_1;
			wdata.first_name_2 = item_q.first_name_2;
			wdata.last_name_0  = item_q.last_name_0;
			wdata.last_name_1  = item_q.last_name_1;
			wdata.last_name_2  = item_q.last_name_2;
			wdata.gpa          = item_q.gpa_hundredths;
		end
		if (state_q == S_MWR) begin
			wen   = 1'b1;
			waddr = SW'(bucket_q) * SW'(WAYS) + SW'(pos_q) - SW'(1);
		end
		if (state_q != S_RD)
			raddr = SW'(bucket_q) * SW'(WAYS) + SW'(pos_q);
	end

	assign mod_start = (state_q == S_IDLE) && in_valid &&
		(in_data.func == FUNC_ADD || in_data.func == FUNC_DEL);
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			clr_q    <= '0;
			bcount_q <= BUCKET_COUNT_RESET;
		end else begin
			if (cfg_we) bcount_q <= cfg_wdata;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BW'(BUCKETS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						if (in_data.func == FUNC_ADD || in_data.func == FUNC_DEL)
							state_q <= S_MOD;
						else if (in_data.func == FUNC_RD && {1'b0, in_data.slot_index} < 10'(NS))
							state_q <= S_RD;
						else
							state_q <= S_OUT;
					end
				end
				S_MOD: if (mod_done) state_q <= S_FILL;
				S_FILL: begin
					if (item_q.func == FUNC_ADD) state_q <= S_OUT;
					else state_q <= S_SRCH;
				end
				S_SRCH: begin
					if (FW'(pos_q) >= cur_fill_q) state_q <= S_OUT;
					else state_q <= S_SCMP;
				end
				S_SCMP: begin
					if (rdata.key_id == item_q.key_id) state_q <= S_MRD;
					else state_q <= S_SRCH;
				end
				S_MRD: begin
					if (FW'(pos_q) >= cur_fill_q) state_q <= S_OUT;
					else state_q <= S_MWR;
				end
				S_MWR: state_q <= S_MRD;
				S_RD:  state_q <= S_RDW;
				S_RDW: state_q <= S_OUT;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				item_q <= in_data;
				pos_q  <= '0;
				res_q  <= '0;
				if (in_data.func == FUNC_RD) begin
					res_q.status <= ST_EMPTY;
					if ({1'b0, in_data.slot_index} < 10'(NS)) begin
						bucket_q <= BW'(in_data.slot_index / WAYS);
						res_q.bucket_index <= 7'(in_data.slot_index / WAYS);
					end
				end
			end
			S_MOD: begin
				bucket_q <= BW'(mod_rem);
				res_q.bucket_index <= 7'(mod_rem);
			end
			S_FILL: begin
				cur_fill_q <= fill_rdata;
				if (item_q.func == FUNC_ADD) begin
					if (fill_rdata >= FW'(WAYS)) begin
						res_q.status <= ST_FULL;
						res_q.bucket_fill_count <= 3'(fill_rdata);
					end else begin
						res_q.bucket_fill_count <= 3'(fill_rdata + 1'b1);
					end
				end
			end
			S_SRCH: begin
				if (FW'(pos_q) >= cur_fill_q) begin
					res_q.status <= ST_NOT_FOUND;
					res_q.bucket_fill_count <= 3'(cur_fill_q);
				end
			end
			S_SCMP: begin
				pos_q <= pos_q + 1'b1;
				if (rdata.key_id == item_q.key_id)
					res_q.bucket_fill_count <= 3'(cur_fill_q - 1'b1);
			end
			S_MWR: pos_q <= pos_q + 1'b1;
			S_RDW: begin
				res_q.bucket_fill_count <= 3'(fill_rdata);
				if (WAYS == 1 ? (fill_rdata != '0) :
					(FW'(slot_ext % WAYS) < fill_rdata)) begin
					res_q.status           <= ST_OK;
					res_q.out_key_id       <= rdata.key_id;
					res_q.out_first_name_0 <= rdata.first_name_0;
					res_q.out_first_name_1 <= rdata.first_name_1;
					res_q.out_first_name_2 <= rdata.first_name_2;
					res_q.out_last_name_0  <= rdata.last_name_0;
					res_q.out_last_name_1  <= rdata.last_name_1;
					res_q.out_last_name_2  <= rdata.last_name_2;
					res_q.out_gpa          <= rdata.gpa;
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: design/bht_mod.sv
// Sequential remainder unit: key modulo divisor, one quotient bit per cycle.
module bht_mod
	import bht_pkg::*;
#(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [30:0]   dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] remainder
);

	localparam int CW = $clog2(32);

	logic [30:0]   num_q;
	logic [DW:0]   rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   shifted;
	logic [DW:0]   diff;

	assign shifted = {rem_q[DW-1:0], num_q[30]};
	assign diff    = shifted - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(30)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[29:0], 1'b0};
			rem_q <= diff[DW] ? shifted : diff;
		end
	end

	assign remainder = rem_q[DW-1:0];

endmodule

FILE: design/bht_checker.sv
// Port-level checker for the bucketed hash table, bound to the top level.
module bht_checker
	import bht_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input bht_out_t out_data
);

	// no new transaction while a result is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken with result pending");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped or changed under stall");

	// id and gpa fields are zero unless the read succeeded
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.out_key_id == '0 &&
		out_data.out_gpa == '0) else $error("payload not zero on failure");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_FULL |-> out_data.bucket_fill_count != 3'd0)
		else $error("full status with empty bucket");

endmodule

bind bucketed_hash_table_by_id bht_checker u_bht_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

FILE: sim/tb_top.sv
// Testbench for the bucketed hash table: queued driver, clocked monitor, record-table predictor.
module tb_top;
	import bht_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BKTS = 128;
	localparam int NWAY = 4;
	localparam int NSLOT = BKTS * NWAY;
	localparam int WATCH_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	bht_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	bht_out_t out_data;
	logic cfg_we = 1'b0;
	logic [7:0] cfg_wdata = '0;
	logic in_taken = 1'b0;

	bucketed_hash_table_by_id dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	logic [7:0] tbl_bucket_count;
	logic [2:0] tbl_fill [BKTS];
	bht_rec_t tbl_rec [NSLOT];
	logic [30:0] live_ids [$];

	bht_in_t pending_ops [$];
	bht_out_t expected_results [$];
	int errors = 0;
	int send_idle_pct = 8;
	int recv_idle_pct = 62;
	int hold_recv = 0;
	int quiet_cycles = 0;

	function automatic int eff_divisor();
		int d;
		d = tbl_bucket_count;
		if (d == 0) d = 1;
		if (d > BKTS) d = BKTS;
		return d;
	endfunction

	function automatic bht_out_t apply_op(bht_in_t op);
		bht_out_t r;
		int b, f, pos, s;
		bht_rec_t rec;
		r = '0;
		case (op.func)
			FUNC_ADD: begin
				b = op.key_id % eff_divisor();
				f = tbl_fill[b];
				if (f >= NWAY) begin
					r.status = ST_FULL;
				end else begin
					rec.key_id = op.key_id;
					rec.first_name_0 = op.first_name_0;
					rec.first_name_1 = op.first_name_1;
					rec.first_name_2 = op.first_name_2;
					rec.last_name_0 = op.last_name_0;
					rec.last_name_1 = op.last_name_1;
					rec.last_name_2 = op.last_name_2;
					rec.gpa = op.gpa_hundredths;
					tbl_rec[b * NWAY + f] = rec;
					f++;
					tbl_fill[b] = f[2:0];
					r.status = ST_OK;
				end
				r.bucket_index = b[6:0];
				r.bucket_fill_count = f[2:0];
			end
			FUNC_DEL: begin
				b = op.key_id % eff_divisor();
				f = tbl_fill[b];
				pos = NWAY;
				for (int k = f - 1; k >= 0; k--)
					if (tbl_rec[b * NWAY + k].key_id == op.key_id) pos = k;
				if (pos >= f) begin
					r.status = ST_NOT_FOUND;
				end else begin
					for (int k = pos; k + 1 < f; k++)
						tbl_rec[b * NWAY + k] = tbl_rec[b * NWAY + k + 1];
					f--;
					tbl_fill[b] = f[2:0];
					r.status = ST_OK;
				end
				r.bucket_index = b[6:0];
				r.bucket_fill_count = f[2:0];
			end
			FUNC_RD: begin
				s = op.slot_index;
				r.status = ST_EMPTY;
				if (s < NSLOT) begin
					b = s / NWAY;
					f = tbl_fill[b];
					r.bucket_index = b[6:0];
					r.bucket_fill_count = f[2:0];
					if (s % NWAY < f) begin
						rec = tbl_rec[s];
						r.status = ST_OK;
						r.out_key_id = rec.key_id;
						r.out_first_name_0 = rec.first_name_0;
						r.out_first_name_1 = rec.first_name_1;
						r.out_first_name_2 = rec.first_name_2;
						r.out_last_name_0 = rec.last_name_0;
						r.out_last_name_1 = rec.last_name_1;
						r.out_last_name_2 = rec.last_name_2;
						r.out_gpa = rec.gpa;
					end
				end
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	// driver: in_taken marks the transaction accepted at the last rising edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken) begin
				if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_data <= pending_ops.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end else if (!in_valid && pending_ops.size() > 0 &&
					$urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_data <= pending_ops.pop_front();
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_recv > 0) begin
				hold_recv <= hold_recv - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			in_taken <= in_valid && in_ready;
			if (in_valid && in_ready) expected_results = {expected_results, apply_op(in_data)};
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCH_LIMIT) begin
				$display("%0t watchdog: no transaction for %0d cycles", $realtime, WATCH_LIMIT);
				$display("Verification failed");
				$finish;
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t unexpected result %h", $realtime, out_data);
					errors++;
				end else begin
					bht_out_t e;
					e = expected_results.pop_front();
					if (e.status !== out_data.status ||
							e.bucket_index !== out_data.bucket_index ||
							e.bucket_fill_count !== out_data.bucket_fill_count ||
							e.out_key_id !== out_data.out_key_id ||
							e.out_first_name_0 !== out_data.out_first_name_0 ||
							e.out_first_name_1 !== out_data.out_first_name_1 ||
							e.out_first_name_2 !== out_data.out_first_name_2 ||
							e.out_last_name_0 !== out_data.out_last_name_0 ||
							e.out_last_name_1 !== out_data.out_last_name_1 ||
							e.out_last_name_2 !== out_data.out_last_name_2 ||
							e.out_gpa !== out_data.out_gpa) begin
						$display("%0t mismatch: expected %h actual %h", $realtime, e, out_data);
						errors++;
					end
				end
			end
		end
	end

	function automatic bht_in_t make_op(logic [1:0] f, logic [30:0] id, logic [8:0] slot);
		bht_in_t op;
		op.func = f;
		op.key_id = id;
		op.first_name_0 = {$urandom, $urandom};
		op.first_name_1 = {$urandom, $urandom};
		op.first_name_2 = $urandom;
		op.last_name_0 = {$urandom, $urandom};
		op.last_name_1 = {$urandom, $urandom};
		op.last_name_2 = $urandom;
		op.gpa_hundredths = 10'($urandom_range(1023));
		op.slot_index = slot;
		return op;
	endfunction

	task automatic wait_drained();
		while (pending_ops.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_bucket_count(logic [7:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		tbl_bucket_count = v;
	endtask

	// pick an id, biased toward ids already stored and toward a few hot buckets
	function automatic logic [30:0] pick_id();
		int r;
		r = $urandom_range(99);
		if (r < 35 && live_ids.size() > 0) return live_ids[$urandom_range(live_ids.size() - 1)];
		if (r < 75) return 31'($urandom_range(15)) * 31'(tbl_bucket_count == 0 ? 1 : tbl_bucket_count)
				+ 31'($urandom_range(7));
		return 31'($urandom);
	endfunction

	task automatic random_phase(int n);
		bht_in_t op;
		int r;
		logic [30:0] id;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			id = pick_id();
			if (r < 40) begin
				op = make_op(FUNC_ADD, id, 9'($urandom));
				live_ids = {live_ids, id};
			end else if (r < 65) begin
				op = make_op(FUNC_DEL, id, 9'($urandom));
			end else if (r < 97) begin
				op = make_op(FUNC_RD, id, (r < 94) ? 9'($urandom_range(63)) : 9'($urandom));
			end else begin
				op = make_op(FUNC_UNUSED, id, 9'($urandom));
			end
			pending_ops = {pending_ops, op};
		end
	endtask

	initial begin
		bht_in_t op;
		tbl_bucket_count = BUCKET_COUNT_RESET;
		foreach (tbl_fill[i]) tbl_fill[i] = '0;
		foreach (tbl_rec[i]) tbl_rec[i] = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: fill one bucket past full, duplicates, delete and miss, reads of that bucket and others, unused func
		for (int i = 0; i < 5; i++)
			pending_ops = {pending_ops, make_op(FUNC_ADD, 31'd7 + 31'(i * 100), 9'd0)};
		op = make_op(FUNC_ADD, 31'h7fffffff, 9'd0);
		op.first_name_0 = '1; op.first_name_1 = '1; op.first_name_2 = '1;
		op.last_name_0 = '1; op.last_name_1 = '1; op.last_name_2 = '1;
		op.gpa_hundredths = '1;
		pending_ops = {pending_ops, op};
		pending_ops = {pending_ops, make_op(FUNC_ADD, 31'd0, 9'd0)};
		pending_ops = {pending_ops, make_op(FUNC_ADD, 31'd0, 9'd0)};
		for (int i = 28; i < 32; i++)
			pending_ops = {pending_ops, make_op(FUNC_RD, 31'd0, 9'(i))};
		pending_ops = {pending_ops, make_op(FUNC_DEL, 31'd107, 9'd0)};
		pending_ops = {pending_ops, make_op(FUNC_DEL, 31'd107, 9'd0)};
		pending_ops = {pending_ops, make_op(FUNC_DEL, 31'd0, 9'd0)};
		for (int i = 0; i < 3; i++)
			pending_ops = {pending_ops, make_op(FUNC_RD, 31'd0, 9'(i))};
		pending_ops = {pending_ops, make_op(FUNC_RD, 31'd0, 9'd511)};
		pending_ops = {pending_ops, make_op(FUNC_RD, 31'd0, 9'd400)};
		op = make_op(FUNC_RD, 31'd0, 9'h1ff);
		op.first_name_0 = '0; op.last_name_0 = '0; op.gpa_hundredths = '0;
		pending_ops = {pending_ops, op};
		pending_ops = {pending_ops, make_op(FUNC_UNUSED, 31'h7fffffff, 9'h1ff)};
		wait_drained();

		// long receiver hold-off while items keep coming
		hold_recv = 400;
		random_phase(40);
		wait_drained();

		write_bucket_count(8'd1);
		random_phase(120);
		wait_drained();
		write_bucket_count(8'd0);
		random_phase(60);
		wait_drained();
		send_idle_pct = 62; recv_idle_pct = 8;
		write_bucket_count(8'd128);
		random_phase(150);
		wait_drained();
		write_bucket_count(8'd255);
		random_phase(120);
		wait_drained();
		send_idle_pct = 0; recv_idle_pct = 0;
		write_bucket_count(8'd3);
		random_phase(150);
		wait_drained();
		write_bucket_count(8'd100);
		random_phase(180);
		wait_drained();

		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
